[hw/rtl/iirf_pkg.sv]
// Shared types and constants of the multichannel direct-form-I IIR filter.
package iirf_pkg;

   localparam int ORDER     = 3;
   localparam int MAX_ORDER = 3;
   localparam int CHANNELS  = 2;
   localparam int MAX_CHAN  = 2;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 24;
   localparam int FRAC_W   = 20;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = PROD_W + 3;
   localparam int CSR_ADDR_W = 3;

   localparam logic signed [COEF_W-1:0] COEF_B0_RESET = COEF_W'(1 << FRAC_W);
   localparam logic signed [ACC_W-1:0]  ROUND_BIAS = ACC_W'(1) << (FRAC_W - 1);
   localparam logic signed [ACC_W-1:0]  SAT_MAX = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0]  SAT_MIN = ~SAT_MAX;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_B0 = 3'd0,
      CSR_B1 = 3'd1,
      CSR_B2 = 3'd2,
      CSR_B3 = 3'd3,
      CSR_A1 = 3'd4,
      CSR_A2 = 3'd5,
      CSR_A3 = 3'd6
   } csr_idx_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_word_type;

   // b[i] weights the input i steps back; a[i] weights the output i+1 steps back.
   typedef struct {
      coef_word_type b [MAX_ORDER+1];
      coef_word_type a [MAX_ORDER];
   } coef_type;

   typedef struct packed {
      logic load_prod;
      logic load_sum;
      logic load_out;
   } lane_ctrl_type;

   typedef struct packed {
      sample_type y;
      logic       clip;
   } lane_res_type;

endpackage

[hw/rtl/iirf_lane.sv]
// One channel of the filter: feedforward products, their sum, and the feedback step.
module iirf_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  iirf_pkg::lane_ctrl_type ctrl,
   input  iirf_pkg::coef_type      coef,
   input  iirf_pkg::sample_type    sample,
   output iirf_pkg::lane_res_type  res
);

   iirf_pkg::sample_type in_hist_ff  [iirf_pkg::ORDER];
   iirf_pkg::sample_type out_hist_ff [iirf_pkg::ORDER];

   logic signed [iirf_pkg::PROD_W-1:0] prod_in [iirf_pkg::ORDER+1];
   logic signed [iirf_pkg::PROD_W-1:0] prod_ff [iirf_pkg::ORDER+1];
   logic signed [iirf_pkg::ACC_W-1:0]  ff_sum_in;
   logic signed [iirf_pkg::ACC_W-1:0]  ff_sum_ff;
   logic signed [iirf_pkg::ACC_W-1:0]  fb_acc;
   logic signed [iirf_pkg::ACC_W-1:0]  rnd;
   logic signed [iirf_pkg::PROD_W-1:0] fb_prod [iirf_pkg::ORDER];

   // Feedforward products use the new sample and the stored input history.
   always_comb begin
      prod_in[0] = iirf_pkg::PROD_W'(coef.b[0]) * iirf_pkg::PROD_W'(sample);
      for (int i = 1; i <= iirf_pkg::ORDER; i++) begin
         prod_in[i] = iirf_pkg::PROD_W'(coef.b[i]) * iirf_pkg::PROD_W'(in_hist_ff[i-1]);
      end
   end

   always_comb begin
      ff_sum_in = '0;
      for (int i = 0; i <= iirf_pkg::ORDER; i++) begin
         ff_sum_in = ff_sum_in + iirf_pkg::ACC_W'(prod_ff[i]);
      end
   end

   // The feedback terms are combinational and close the output-history loop through out_hist_ff.
   always_comb begin
      fb_acc = ff_sum_ff;
      for (int i = 0; i < iirf_pkg::ORDER; i++) begin
         fb_prod[i] = iirf_pkg::PROD_W'(coef.a[i]) * iirf_pkg::PROD_W'(out_hist_ff[i]);
         fb_acc = fb_acc - iirf_pkg::ACC_W'(fb_prod[i]);
      end
      rnd = (fb_acc + iirf_pkg::ROUND_BIAS) >>> iirf_pkg::FRAC_W;
      if (rnd > iirf_pkg::SAT_MAX) begin
         res.y    = iirf_pkg::SAT_MAX[iirf_pkg::SAMPLE_W-1:0];
         res.clip = 1'b1;
      end else if (rnd < iirf_pkg::SAT_MIN) begin
         res.y    = iirf_pkg::SAT_MIN[iirf_pkg::SAMPLE_W-1:0];
         res.clip = 1'b1;
      end else begin
         res.y    = rnd[iirf_pkg::SAMPLE_W-1:0];
         res.clip = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         prod_ff <= prod_in;
      end
      if (ctrl.load_sum) begin
         ff_sum_ff <= ff_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < iirf_pkg::ORDER; i++) begin
            in_hist_ff[i]  <= '0;
            out_hist_ff[i] <= '0;
         end
      end else begin
         if (ctrl.load_prod) begin
            in_hist_ff[0] <= sample;
            for (int i = 1; i < iirf_pkg::ORDER; i++) begin
               in_hist_ff[i] <= in_hist_ff[i-1];
            end
         end
         if (ctrl.load_out) begin
            out_hist_ff[0] <= res.y;
            for (int i = 1; i < iirf_pkg::ORDER; i++) begin
               out_hist_ff[i] <= out_hist_ff[i-1];
            end
         end
      end
   end

endmodule

[hw/rtl/iirf_merge.sv]
// Output stage: collects the lane results into one result beat and flags clipping.
module iirf_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  iirf_pkg::lane_res_type lane_res [iirf_pkg::MAX_CHAN],
   output logic                   ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output iirf_pkg::sample_type   rsp_out_ch0,
   output iirf_pkg::sample_type   rsp_out_ch1,
   output logic                   rsp_saturated
);

   logic                 valid_ff;
   iirf_pkg::sample_type ch0_ff;
   iirf_pkg::sample_type ch1_ff;
   logic                 sat_ff;
   logic                 sat_in;

   always_comb begin
      sat_in = 1'b0;
      for (int c = 0; c < iirf_pkg::MAX_CHAN; c++) begin
         sat_in = sat_in | lane_res[c].clip;
      end
   end

   assign ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ch0_ff <= lane_res[0].y;
         ch1_ff <= lane_res[1].y;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_ch0   = ch0_ff;
   assign rsp_out_ch1   = ch1_ff;
   assign rsp_saturated = sat_ff;

endmodule

[hw/rtl/multichannel_iir_filter.sv]
// Top level of the two-channel third-order direct-form-I IIR filter.
// This block filters two sample channels with one shared set of Q3.20 coefficients
// (b0..b3, a1..a3, already divided by a0), written through the csr_ port at indexes 0 to 6;
// the user must write them only while the block is idle, which the block does not
// enforce, and other indexes are ignored. Each request beat carries one 16-bit sample
// per channel and yields exactly one response beat with both filtered outputs, rounded
// to nearest (ties upward) and saturated to 16 bits, plus a flag that is set when
// either channel clipped. The block takes one beat per clock cycle while the response
// side does not stall: the products are captured at acceptance, then their sum is
// registered, then the feedback terms are applied, rounded and saturated into the
// response register. The rate of one beat per cycle is set by the output-history loop,
// which the feedback stage closes combinationally. Each channel runs in its own lane,
// and the lanes advance together. Empty pipeline stages still take beats while a
// response is stalled, so up to three beats can be held inside. Histories and
// coefficients return to their initial values on reset: b0 equals one, all others zero.
module multichannel_iir_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [iirf_pkg::SAMPLE_W-1:0] req_sample_ch0,
   input  logic signed [iirf_pkg::SAMPLE_W-1:0] req_sample_ch1,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [iirf_pkg::SAMPLE_W-1:0] rsp_out_ch0,
   output logic signed [iirf_pkg::SAMPLE_W-1:0] rsp_out_ch1,
   output logic                                 rsp_saturated,
   input  logic                                 csr_we,
   input  logic [iirf_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic signed [iirf_pkg::COEF_W-1:0]   csr_wdata
);

   iirf_pkg::coef_type      coef_ff;
   iirf_pkg::coef_type      coef_in;
   iirf_pkg::lane_ctrl_type ctrl;
   iirf_pkg::lane_res_type  lane_res [iirf_pkg::MAX_CHAN];
   iirf_pkg::sample_type    samples  [iirf_pkg::MAX_CHAN];

   logic prod_valid_ff;
   logic sum_valid_ff;
   logic out_ready;
   logic sum_ready;
   logic prod_ready;

   // Coefficient registers. A write to an index past the list changes nothing.
   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         unique case (csr_addr)
            iirf_pkg::CSR_B0: coef_in.b[0] = csr_wdata;
            iirf_pkg::CSR_B1: coef_in.b[1] = csr_wdata;
            iirf_pkg::CSR_B2: coef_in.b[2] = csr_wdata;
            iirf_pkg::CSR_B3: coef_in.b[3] = csr_wdata;
            iirf_pkg::CSR_A1: coef_in.a[0] = csr_wdata;
            iirf_pkg::CSR_A2: coef_in.a[1] = csr_wdata;
            iirf_pkg::CSR_A3: coef_in.a[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= iirf_pkg::MAX_ORDER; i++) begin
            coef_ff.b[i] <= '0;
         end
         for (int i = 0; i < iirf_pkg::MAX_ORDER; i++) begin
            coef_ff.a[i] <= '0;
         end
         coef_ff.b[0] <= iirf_pkg::COEF_B0_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Pipeline control. Each stage takes a new beat when it is empty or its
   // occupant moves on in the same cycle, so bubbles close up under a stall.
   assign sum_ready  = !sum_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || sum_ready;
   assign req_stall  = !prod_ready;

   assign ctrl.load_prod = req_valid && prod_ready;
   assign ctrl.load_sum  = prod_valid_ff && sum_ready;
   assign ctrl.load_out  = sum_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= req_valid;
         end
         if (sum_ready) begin
            sum_valid_ff <= prod_valid_ff;
         end
      end
   end

   assign samples[0] = req_sample_ch0;
   assign samples[1] = req_sample_ch1;

   // One lane per active channel; an unused channel reports zero and never clips.
   for (genvar c = 0; c < iirf_pkg::MAX_CHAN; c++) begin : g_lane
      if (c < iirf_pkg::CHANNELS) begin : g_on
         iirf_lane u_lane (
            .clock  (clock),
            .reset  (reset),
            .ctrl   (ctrl),
            .coef   (coef_ff),
            .sample (samples[c]),
            .res    (lane_res[c])
         );
      end else begin : g_off
         assign lane_res[c] = '0;
      end
   end

   iirf_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .load          (ctrl.load_out),
      .lane_res      (lane_res),
      .ready         (out_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_ch0   (rsp_out_ch0),
      .rsp_out_ch1   (rsp_out_ch1),
      .rsp_saturated (rsp_saturated)
   );

   // A clipped response must carry a full-scale value on some channel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_out_ch0 == 16'sh7fff) || (rsp_out_ch0 == -16'sh8000) ||
         (rsp_out_ch1 == 16'sh7fff) || (rsp_out_ch1 == -16'sh8000))
      else $error("saturation flag without a full-scale output");

   // An empty first stage never pushes back on the request side.
   assert property (@(posedge clock) disable iff (reset)
      !prod_valid_ff |-> !req_stall)
      else $error("request stalled while the first stage is empty");

   // A summed beat waits in place until the response register takes it.
   assert property (@(posedge clock) disable iff (reset)
      sum_valid_ff && !ctrl.load_out |=> sum_valid_ff)
      else $error("beat lost between the sum stage and the response register");

   // A beat that leaves the sum stage is captured as a valid response.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.load_out |=> rsp_valid)
      else $error("response register did not capture a finished beat");

endmodule

[sim/tb_multichannel_iir_filter.sv]
// Self-checking testbench of the two-channel third-order direct-form-I IIR filter.
module tb_multichannel_iir_filter;
   import iirf_pkg::*;

   // Register index past the last coefficient; the block must ignore writes to it.
   localparam logic [CSR_ADDR_W-1:0] CSR_NONE = 3'd7;
   localparam coef_word_type COEF_MAX = 24'sh7FFFFF;
   localparam coef_word_type COEF_MIN = 24'sh800000;
   localparam sample_type SMP_MAX = 16'sh7FFF;
   localparam sample_type SMP_MIN = 16'sh8000;
   localparam int RANDOM_PHASES = 12;
   localparam int BEATS_PER_PHASE = 110;

   // Idling schemes that the random phases rotate through.
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // Coefficient sets that the random phases rotate through.
   typedef enum int {COEFS_STABLE, COEFS_ANY, COEFS_EXTREME} coef_mode_type;

   typedef struct packed {
      sample_type s0;
      sample_type s1;
   } sample_pair_type;

   typedef struct packed {
      sample_type y0;
      sample_type y1;
      logic       sat;
   } filter_out_type;

   logic                      clock;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   sample_type                req_sample_ch0 = '0;
   sample_type                req_sample_ch1 = '0;
   logic                      rsp_valid;
   logic                      rsp_stall      = 1'b0;
   sample_type                rsp_out_ch0;
   sample_type                rsp_out_ch1;
   logic                      rsp_saturated;
   logic                      csr_we         = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_addr       = '0;
   coef_word_type             csr_wdata      = '0;

   // Sample beats waiting to be driven, and filter outputs waiting to be seen.
   sample_pair_type pending_samples [$];
   filter_out_type  expected_outputs [$];

   // Shadow copy of the coefficient registers and the per-channel delay lines.
   coef_type   coefs;
   sample_type in_hist  [MAX_CHAN][ORDER];
   sample_type out_hist [MAX_CHAN][ORDER];

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int          err_count     = 0;
   sample_pair_type next_pair;
   filter_out_type  want;

   multichannel_iir_filter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_ch0 (req_sample_ch0),
      .req_sample_ch1 (req_sample_ch1),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_ch0    (rsp_out_ch0),
      .rsp_out_ch1    (rsp_out_ch1),
      .rsp_saturated  (rsp_saturated),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs; a correct run takes only a small part of this.
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // Advances the filter model by one beat and queues the output it must produce.
   // Each channel sums the exact Q.20 products, rounds to nearest with ties upward,
   // which is an arithmetic shift after adding half an LSB, then clips to 16 bits.
   task automatic filter_step(input sample_pair_type smp);
      longint         acc;
      longint         y;
      logic           sat;
      sample_type     u;
      sample_type     ys [MAX_CHAN];
      filter_out_type res;
      sat = 1'b0;
      for (int c = 0; c < MAX_CHAN; c++) ys[c] = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         u = (c == 0) ? smp.s0 : smp.s1;
         acc = longint'(coefs.b[0]) * longint'(u);
         for (int i = 1; i <= ORDER; i++) begin
            acc += longint'(coefs.b[i]) * longint'(in_hist[c][i-1]);
            acc -= longint'(coefs.a[i-1]) * longint'(out_hist[c][i-1]);
         end
         y = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
         if (y > longint'(SMP_MAX)) begin
            y = longint'(SMP_MAX);
            sat = 1'b1;
         end else if (y < longint'(SMP_MIN)) begin
            y = longint'(SMP_MIN);
            sat = 1'b1;
         end
         // The clipped value, not the raw sum, is what feeds back.
         for (int i = ORDER - 1; i > 0; i--) begin
            in_hist[c][i]  = in_hist[c][i-1];
            out_hist[c][i] = out_hist[c][i-1];
         end
         in_hist[c][0]  = u;
         out_hist[c][0] = sample_type'(y);
         ys[c] = sample_type'(y);
      end
      res.y0  = ys[0];
      res.y1  = ys[1];
      res.sat = sat;
      expected_outputs.push_back(res);
   endtask

   // Driver: a beat that is held stays untouched until it is taken; a new one is
   // offered only when the port is empty or the current beat was accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            filter_step('{s0: req_sample_ch0, s1: req_sample_ch1});
         end
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_pair = pending_samples.pop_front();
               req_valid      <= 1'b1;
               req_sample_ch0 <= next_pair.s0;
               req_sample_ch1 <= next_pair.s1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: every response beat is matched against the oldest predicted output.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               $error("response beat with no sample beat outstanding");
               err_count++;
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_out_ch0 !== want.y0) begin
                  $error("out_ch0: expected %0d, actual %0d", want.y0, rsp_out_ch0);
                  err_count++;
               end
               if (rsp_out_ch1 !== want.y1) begin
                  $error("out_ch1: expected %0d, actual %0d", want.y1, rsp_out_ch1);
                  err_count++;
               end
               if (rsp_saturated !== want.sat) begin
                  $error("saturated: expected %0b, actual %0b", want.sat, rsp_saturated);
                  err_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Returns on a falling edge once no beat is queued, offered or in flight.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_outputs.size() != 0);
   endtask

   // Writes one coefficient register and mirrors it in the model. Only called while idle.
   task automatic write_coef(input logic [CSR_ADDR_W-1:0] idx, input coef_word_type val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_B0, CSR_B1, CSR_B2, CSR_B3: coefs.b[idx] = val;
         CSR_A1, CSR_A2, CSR_A3:         coefs.a[idx - CSR_A1] = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_pair(input sample_type a, input sample_type b);
      pending_samples.push_back('{s0: a, s1: b});
   endtask

   // Mostly full-range noise, with small values that keep the delay lines busy without
   // clipping and the two rails that drive the sums hardest.
   function automatic sample_type rand_sample();
      case ($urandom_range(9))
         0, 1:    return sample_type'(int'($urandom_range(128)) - 64);
         2:       return $urandom_range(1) ? SMP_MAX : SMP_MIN;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic coef_word_type rand_coef(input coef_mode_type mode, input bit feedback);
      case (mode)
         // Feedback taps of at most a quarter each keep the loop stable, so the outputs
         // stay mostly inside range and the histories carry real values.
         COEFS_STABLE:
            if (feedback) return coef_word_type'(int'($urandom_range(1 << 19)) - (1 << 18));
            else          return coef_word_type'(int'($urandom_range(1 << 20)) - (1 << 19));
         COEFS_EXTREME:
            case ($urandom_range(2))
               0:       return COEF_MAX;
               1:       return COEF_MIN;
               default: return '0;
            endcase
         default: return coef_word_type'($urandom);
      endcase
   endfunction

   initial begin
      coef_mode_type cmode;
      idle_mode_type imode;
      for (int i = 0; i <= MAX_ORDER; i++) coefs.b[i] = '0;
      for (int i = 0; i < MAX_ORDER; i++) coefs.a[i] = '0;
      coefs.b[0] = COEF_B0_RESET;
      for (int c = 0; c < MAX_CHAN; c++) begin
         for (int i = 0; i < ORDER; i++) begin
            in_hist[c][i]  = '0;
            out_hist[c][i] = '0;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // With the reset coefficients the filter is a straight copy: rails and bit patterns.
      push_pair(SMP_MAX, SMP_MIN);
      push_pair(SMP_MIN, SMP_MAX);
      push_pair(16'sd0, 16'sd0);
      push_pair(-16'sd1, 16'sd1);
      push_pair(16'sh5555, 16'shAAAA);
      push_pair(16'shAAAA, 16'sh5555);
      wait_idle();

      // A write past the last register must change nothing. A gain of one half puts
      // odd inputs exactly on a rounding tie, which must go upward.
      write_coef(CSR_NONE, COEF_MAX);
      write_coef(CSR_B0, coef_word_type'(1 << (FRAC_W - 1)));
      @(negedge clock);
      push_pair(16'sd1, -16'sd1);
      push_pair(16'sd3, -16'sd3);
      push_pair(SMP_MAX, SMP_MIN);
      wait_idle();

      // Every tap at a rail drives the outputs into clipping on both sides.
      write_coef(CSR_B0, COEF_MAX);
      write_coef(CSR_B1, COEF_MIN);
      write_coef(CSR_B2, COEF_MAX);
      write_coef(CSR_B3, COEF_MIN);
      write_coef(CSR_A1, COEF_MIN);
      write_coef(CSR_A2, COEF_MAX);
      write_coef(CSR_A3, COEF_MIN);
      @(negedge clock);
      push_pair(SMP_MAX, SMP_MIN);
      push_pair(16'sd1, -16'sd1);
      push_pair(16'sd0, 16'sd0);
      push_pair(SMP_MIN, SMP_MAX);
      push_pair(16'sd0, 16'sd0);
      push_pair(16'sd0, 16'sd0);

      // Random phases. Each one begins with the sender holding off until every
      // outstanding response has come back, so the coefficients change on an idle block.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         cmode = coef_mode_type'(ph % 3);
         imode = idle_mode_type'(ph % 4);
         write_coef(CSR_B0, rand_coef(cmode, 1'b0));
         write_coef(CSR_B1, rand_coef(cmode, 1'b0));
         write_coef(CSR_B2, rand_coef(cmode, 1'b0));
         write_coef(CSR_B3, rand_coef(cmode, 1'b0));
         write_coef(CSR_A1, rand_coef(cmode, 1'b1));
         write_coef(CSR_A2, rand_coef(cmode, 1'b1));
         write_coef(CSR_A3, rand_coef(cmode, 1'b1));
         if (ph % 2 == 1) write_coef(CSR_NONE, coef_word_type'($urandom));
         @(negedge clock);
         case (imode)
            IDLE_NONE: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            IDLE_SENDER: begin
               send_idle_pct = 74;
               stall_pct     = 0;
            end
            IDLE_RECEIVER: begin
               send_idle_pct = 0;
               stall_pct     = 74;
            end
            default: begin
               send_idle_pct = 27;
               stall_pct     = 27;
            end
         endcase
         for (int n = 0; n < BEATS_PER_PHASE; n++) push_pair(rand_sample(), rand_sample());
      end

      wait_idle();
      // Leave room for any stray response beat to show up before the verdict.
      repeat (10) @(posedge clock);
      @(negedge clock);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/iirf_pkg.sv
hw/rtl/iirf_lane.sv
hw/rtl/iirf_merge.sv
hw/rtl/multichannel_iir_filter.sv
sim/tb_multichannel_iir_filter.sv
